FILE: src/lesf_pkg.sv
package lesf_pkg;

  // Byte that ends a map row; it always wins over the register characters.
  localparam logic [7:0] NEWLINE = 8'd10;

  // Result error codes
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
  localparam logic [2:0] ERR_WIDTH    = 3'd2;
  localparam logic [2:0] ERR_TOO_WIDE = 3'd3;
  localparam logic [2:0] ERR_CONFIG   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_EMPTY_CHAR    = 2'd0;
  localparam logic [1:0] REG_OBSTACLE_CHAR = 2'd1;
  localparam logic [1:0] REG_FULL_CHAR     = 2'd2;
  localparam logic [1:0] REG_LINE_COUNT    = 2'd3;

  // Configuration reset values
  localparam logic [7:0]  RST_EMPTY_CHAR    = 8'd46;
  localparam logic [7:0]  RST_OBSTACLE_CHAR = 8'd111;
  localparam logic [7:0]  RST_FULL_CHAR     = 8'd120;
  localparam logic [10:0] RST_LINE_COUNT    = 11'd1;

  // Port field widths
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned SIZE_OUT_W = 11;
  localparam int unsigned POS_OUT_W  = 10;

endpackage

FILE: src/lesf_row_buf.sv
module lesf_row_buf #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/largest_empty_square_finder.sv
// Channel   Dir  Handshake               Payload
// -------   ---  ----------------------  -------------------------------------------
// map in    in   in_valid_i/in_ready_o   map_byte_i
// result    out  out_valid_o/out_ready_i error_code_o square_size_o best_row_o
//                                        best_col_o map_width_o
// config    in   cfg_we_i (no wait)      cfg_idx_i cfg_data_i
//
// One byte per cycle sustained, but for the stall below. A byte is held
// in the input stage, where the row buffer read (issued as the byte is
// taken) meets the three-way minimum. A result is registered once the
// last row's newline leaves the input stage.
// Reset clears all control state and config; the row buffer is not cleared.
// Only a last-row newline can stall, and only while the result register is
// still full; cell bytes and other newlines always move on.
module largest_empty_square_finder #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_ROWS  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // map byte request
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  map_byte_i,
  // result request
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  error_code_o,
  output logic [10:0] square_size_o,
  output logic [9:0]  best_row_o,
  output logic [9:0]  best_col_o,
  output logic [10:0] map_width_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i
);

  // Column counts to MAX_WIDTH inclusive (saturates there on too-wide rows);
  // square sizes share that width.
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]  empty_char_q, obstacle_char_q, full_char_q;
  logic [10:0] line_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_char_q    <= lesf_pkg::RST_EMPTY_CHAR;
      obstacle_char_q <= lesf_pkg::RST_OBSTACLE_CHAR;
      full_char_q     <= lesf_pkg::RST_FULL_CHAR;
      line_count_q    <= lesf_pkg::RST_LINE_COUNT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lesf_pkg::REG_EMPTY_CHAR:    empty_char_q    <= cfg_data_i[7:0];
        lesf_pkg::REG_OBSTACLE_CHAR: obstacle_char_q <= cfg_data_i[7:0];
        lesf_pkg::REG_FULL_CHAR:     full_char_q     <= cfg_data_i[7:0];
        lesf_pkg::REG_LINE_COUNT:    line_count_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic cfg_bad;
  assign cfg_bad = (full_char_q == empty_char_q) || (full_char_q == obstacle_char_q) ||
                   (line_count_q == '0) || (32'(line_count_q) > 32'(MAX_ROWS));

  // ---------------------------------------------------------------------------
  // Front end: position counters advance as each request is taken, so the
  // row buffer read for a cell can be launched in the same edge.
  // ---------------------------------------------------------------------------
  logic          in_fire, in_nl, in_last;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [RW:0]   row_inc;
  logic          col_full;

  assign in_fire  = in_valid_i && in_ready_o;
  assign in_nl    = (map_byte_i == lesf_pkg::NEWLINE);
  assign col_full = (col_q == CW'(MAX_WIDTH));
  assign row_inc  = {1'b0, row_q} + {{RW{1'b0}}, 1'b1};
  // Last row when row+1 reaches line_count or MAX_ROWS (line_count zero: first)
  assign in_last  = (32'(row_inc) >= 32'(line_count_q)) ||
                    (32'(row_inc) >= 32'(MAX_ROWS));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (in_nl) begin
        col_d = '0;
        row_d = in_last ? '0 : row_inc[RW-1:0];
      end else if (!col_full) begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage register
  // ---------------------------------------------------------------------------
  logic          s1_valid_q;
  logic [7:0]    s1_byte_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic          s1_last_q;
  logic          s1_nl, s1_emit, s1_fire;
  logic          out_valid_q;

  assign s1_nl      = (s1_byte_q == lesf_pkg::NEWLINE);
  assign s1_emit    = s1_nl && s1_last_q;
  assign s1_fire    = s1_valid_q && (!s1_emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= map_byte_i;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_last_q <= in_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Row buffer: sizes of the row above, one entry per column.
  // ---------------------------------------------------------------------------
  logic          buf_re, buf_we;
  logic [CW-1:0] buf_rdata;
  logic [CW-1:0] cell_val;
  logic          cell_ok;

  assign buf_re  = in_fire && !in_nl && !col_full;
  assign cell_ok = !s1_nl && (s1_col_q != CW'(MAX_WIDTH));
  assign buf_we  = s1_fire && cell_ok;

  lesf_row_buf #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (CW)
  ) u_row_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (s1_col_q[AW-1:0]),
    .wdata_i (cell_val),
    .re_i    (buf_re),
    .raddr_i (col_q[AW-1:0]),
    .rdata_o (buf_rdata)
  );

  // ---------------------------------------------------------------------------
  // Square-size recurrence and row checks
  // ---------------------------------------------------------------------------
  logic [CW-1:0] left_q, diag_q, first_w_q;
  logic [CW-1:0] top_size_q, best_col_q;
  logic [RW-1:0] best_row_q;
  logic [2:0]    err_q;
  logic          row_bad_q, row_wide_q;

  logic          is_obst, is_bad, top_row;
  logic [CW-1:0] up, min_lu, min3;
  logic [2:0]    row_err, err_now, res_err;
  logic [CW-1:0] first_w_now;

  assign top_row = (s1_row_q == '0);
  // Obstacle test wins when empty and obstacle characters are equal;
  // any other character is treated as an obstacle.
  assign is_obst = (s1_byte_q == obstacle_char_q) || (s1_byte_q != empty_char_q);
  assign is_bad  = (s1_byte_q != empty_char_q) && (s1_byte_q != obstacle_char_q);
  assign up      = top_row ? '0 : buf_rdata;
  assign min_lu  = (up < left_q) ? up : left_q;
  assign min3    = (diag_q < min_lu) ? diag_q : min_lu;

  always_comb begin
    if (is_obst) begin
      cell_val = '0;
    end else if (top_row || (s1_col_q == '0)) begin
      cell_val = CW'(1);
    end else begin
      cell_val = min3 + CW'(1);
    end
  end

  // Per-row error priority: width mismatch, then too wide, then bad character
  always_comb begin
    if (!top_row && (s1_col_q != first_w_q)) begin
      row_err = lesf_pkg::ERR_WIDTH;
    end else if (row_wide_q) begin
      row_err = lesf_pkg::ERR_TOO_WIDE;
    end else if (row_bad_q) begin
      row_err = lesf_pkg::ERR_BAD_CHAR;
    end else begin
      row_err = lesf_pkg::ERR_OK;
    end
  end

  assign err_now     = (err_q == lesf_pkg::ERR_OK) ? row_err : err_q;
  assign first_w_now = top_row ? s1_col_q : first_w_q;
  assign res_err     = cfg_bad ? lesf_pkg::ERR_CONFIG : err_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      diag_q      <= '0;
      first_w_q   <= '0;
      top_size_q  <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
      err_q       <= lesf_pkg::ERR_OK;
      row_bad_q   <= 1'b0;
      row_wide_q  <= 1'b0;
    end else if (s1_fire) begin
      if (!s1_nl) begin
        if (!cell_ok) begin
          row_wide_q <= 1'b1;
        end else begin
          row_bad_q <= row_bad_q || is_bad;
          diag_q    <= up;
          left_q    <= cell_val;
          // strict compare: first maximum wins
          if (cell_val > top_size_q) begin
            top_size_q  <= cell_val;
            best_row_q  <= s1_row_q;
            best_col_q  <= s1_col_q;
          end
        end
      end else if (s1_last_q) begin
        // result given: return to the post-reset state
        left_q      <= '0;
        diag_q      <= '0;
        first_w_q   <= '0;
        top_size_q  <= '0;
        best_row_q  <= '0;
        best_col_q  <= '0;
        err_q       <= lesf_pkg::ERR_OK;
        row_bad_q   <= 1'b0;
        row_wide_q  <= 1'b0;
      end else begin
        err_q      <= err_now;
        first_w_q  <= first_w_now;
        left_q     <= '0;
        diag_q     <= '0;
        row_bad_q  <= 1'b0;
        row_wide_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic        res_ok;
  logic [31:0] size_ext, row_ext, col_ext, width_ext;
  logic [2:0]  res_err_q;
  logic [10:0] res_size_q, res_width_q;
  logic [9:0]  res_row_q, res_col_q;

  assign res_ok    = (res_err == lesf_pkg::ERR_OK);
  assign size_ext  = res_ok ? 32'(top_size_q) : '0;
  assign row_ext   = res_ok ? 32'(best_row_q) : '0;
  assign col_ext   = res_ok ? 32'(best_col_q) : '0;
  assign width_ext = 32'(first_w_now);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit) begin
      res_err_q   <= res_err;
      res_size_q  <= size_ext[lesf_pkg::SIZE_OUT_W-1:0];
      res_row_q   <= row_ext[lesf_pkg::POS_OUT_W-1:0];
      res_col_q   <= col_ext[lesf_pkg::POS_OUT_W-1:0];
      res_width_q <= width_ext[lesf_pkg::SIZE_OUT_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign error_code_o  = res_err_q;
  assign square_size_o = res_size_q;
  assign best_row_o    = res_row_q;
  assign best_col_o    = res_col_q;
  assign map_width_o   = res_width_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire && s1_emit))
    else $error("result appeared without a last-row newline");

  a_error_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (error_code_o != lesf_pkg::ERR_OK)) |->
      ((square_size_o == '0) && (best_row_o == '0) && (best_col_o == '0)))
    else $error("nonzero error code with nonzero square fields");

  a_row_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_nl && in_last) |=> (row_q == '0) && (col_q == '0))
    else $error("position counters not cleared after last row");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (32'(s1_col_q) <= 32'(MAX_WIDTH)))
    else $error("column beyond saturation limit");

endmodule
